// File: design/tphc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphc_pkg
// Types and constants shared by the environmental compensation pipeline.
// ----------------------------------------------------------------------------
package tphc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int DivW     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP     = 3'd0,
    REG_PRESS_LO = 3'd1,
    REG_PRESS_HI = 3'd2,
    REG_P9_H1    = 3'd3,
    REG_HUM      = 3'd4
  } reg_idx_t;

  localparam logic signed [32:0] TFinePressOfs = 33'sd128000;
  localparam logic [20:0]        PressFull     = 21'd1048576;
  localparam logic [12:0]        PressScale    = 13'd3125;
  localparam logic [31:0]        TFineHumOfs   = 32'd76800;
  localparam logic [31:0]        HumMax        = 32'd419430400;
  localparam logic [31:0]        HumOfsF       = 32'd2097152;
  localparam logic [31:0]        HumRndA       = 32'd16384;
  localparam logic [31:0]        HumRndF       = 32'd8192;
  localparam logic [31:0]        HumOfsE       = 32'd32768;
  localparam logic [31:0]        TempRnd       = 32'd128;
  localparam logic [63:0]        PressBias     = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temp_centideg;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
  } result_t;

  // divider transaction: magnitudes, sign of quotient, zero divisor, side data
  typedef struct packed {
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
    logic            neg;
    logic            zero;
    result_t         tag;
  } div_xact_t;

endpackage

// File: design/tphc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tphc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tphc_pkg::div_xact_t in_data,
  output logic                out_valid,
  output tphc_pkg::div_xact_t out_data
);

  localparam int N = tphc_pkg::DivW;

  typedef struct packed {
    logic [N-1:0]      rem;
    logic [N-1:0]      acc;
    logic [N-1:0]      den;
    logic              neg;
    logic              zero;
    tphc_pkg::result_t tag;
  } step_t;

  function automatic step_t div_step(input step_t s);
    step_t    o;
    logic [N:0] r;
    logic [N:0] diff;
    o    = s;
    r    = {s.rem, s.acc[N-1]};
    diff = r - {1'b0, s.den};
    if (!diff[N]) begin
      o.rem = diff[N-1:0];
      o.acc = {s.acc[N-2:0], 1'b1};
    end else begin
      o.rem = r[N-1:0];
      o.acc = {s.acc[N-2:0], 1'b0};
    end
    return o;
  endfunction

  step_t      st_in;
  step_t      st  [1:N];
  logic [N:1] vld;

  always_comb begin
    st_in.rem  = '0;
    st_in.acc  = in_data.num;
    st_in.den  = in_data.den;
    st_in.neg  = in_data.neg;
    st_in.zero = in_data.zero;
    st_in.tag  = in_data.tag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1] <= div_step(st_in);
      for (int i = 1; i < N; i++) begin
        st[i+1] <= div_step(st[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-1:1], in_valid};
    end
  end

  assign out_valid     = vld[N];
  assign out_data.num  = st[N].acc;
  assign out_data.den  = st[N].den;
  assign out_data.neg  = st[N].neg;
  assign out_data.zero = st[N].zero;
  assign out_data.tag  = st[N].tag;

endmodule

// File: design/temp_press_hum_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_press_hum_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
//  channel   signals                               handshake
//  sample    sample_valid, sample_stall, sample    valid / stall
//  result    result_valid, result_stall, result    valid / stall
//  config    cfg_valid, cfg_ready, cfg_index/data  valid / ready
//
//  One transaction per cycle unless sample_stall is high; the path from accept
//  to result_valid runs through the 64-stage pressure divider plus 14 front,
//  6 back and one output stage.
//  Reset clears valid bits and the calibration registers.
//  A stalled result parks the next one in a skid register; the pipeline then freezes.
// ----------------------------------------------------------------------------
module temp_press_hum_compensation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  tphc_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tphc_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tphc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tphc_pkg::CfgDataW-1:0]   cfg_data
);

  // calibration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [23:0] p9_h1;
  logic [63:0] hum_coeffs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_lo    <= '0;
      press_hi    <= '0;
      p9_h1       <= '0;
      hum_coeffs  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tphc_pkg::REG_TEMP:     temp_coeffs <= cfg_data[47:0];
        tphc_pkg::REG_PRESS_LO: press_lo    <= cfg_data;
        tphc_pkg::REG_PRESS_HI: press_hi    <= cfg_data;
        tphc_pkg::REG_P9_H1:    p9_h1       <= cfg_data[23:0];
        tphc_pkg::REG_HUM:      hum_coeffs  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0]         h1, h3;
  logic signed [15:0] h2, h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = press_lo[15:0];
  assign p2 = $signed(press_lo[31:16]);
  assign p3 = $signed(press_lo[47:32]);
  assign p4 = $signed(press_lo[63:48]);
  assign p5 = $signed(press_hi[15:0]);
  assign p6 = $signed(press_hi[31:16]);
  assign p7 = $signed(press_hi[47:32]);
  assign p8 = $signed(press_hi[63:48]);
  assign p9 = $signed(p9_h1[15:0]);
  assign h1 = p9_h1[23:16];
  assign h2 = $signed(hum_coeffs[15:0]);
  assign h3 = hum_coeffs[23:16];
  assign h4 = $signed(hum_coeffs[39:24]);
  assign h5 = $signed(hum_coeffs[55:40]);
  assign h6 = $signed(hum_coeffs[63:56]);

  // pipeline control
  logic        en;
  logic [14:1] pre_v;
  logic [6:1]  post_v;
  logic        div_out_v;
  logic        skid_v;
  tphc_pkg::result_t skid_d;
  tphc_pkg::result_t tail_d;

  assign en           = !skid_v;
  assign sample_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_v  <= '0;
      post_v <= '0;
    end else if (en) begin
      pre_v  <= {pre_v[13:1], sample_valid};
      post_v <= {post_v[5:1], div_out_v};
    end
  end

  // stage 1: temperature products
  logic signed [17:0] ta_diff, td;
  logic signed [33:0] ta_full;
  logic signed [35:0] dd_full;
  logic [31:0] s1_ta, s1_dd;
  logic [19:0] s1_ap;
  logic [15:0] s1_ah;

  assign ta_diff = $signed({1'b0, sample.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td      = $signed({2'b0, sample.raw_temp[19:4]}) - $signed({2'b0, t1});
  assign ta_full = ta_diff * t2;
  assign dd_full = td * td;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta <= ta_full[31:0];
      s1_dd <= dd_full[31:0];
      s1_ap <= sample.raw_press;
      s1_ah <= sample.raw_hum;
    end
  end

  // stage 2
  logic signed [31:0] dd_sh;
  logic signed [47:0] bt_full;
  logic [31:0] s2_a, s2_bt;
  logic [19:0] s2_ap;
  logic [15:0] s2_ah;

  assign dd_sh   = $signed(s1_dd) >>> 12;
  assign bt_full = dd_sh * t3;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a  <= 32'($signed(s1_ta) >>> 11);
      s2_bt <= bt_full[31:0];
      s2_ap <= s1_ap;
      s2_ah <= s1_ah;
    end
  end

  // stage 3: fine temperature
  logic [31:0] s3_tf;
  logic [19:0] s3_ap;
  logic [15:0] s3_ah;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tf <= s2_a + 32'($signed(s2_bt) >>> 14);
      s3_ap <= s2_ap;
      s3_ah <= s2_ah;
    end
  end

  // stage 4
  logic [31:0] t5;
  logic [31:0] s4_temp, s4_xh;
  logic signed [32:0] s4_v1;
  logic [19:0] s4_ap;
  logic [15:0] s4_ah;

  assign t5 = (s3_tf << 2) + s3_tf + tphc_pkg::TempRnd;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_temp <= 32'($signed(t5) >>> 8);
      s4_v1   <= $signed({s3_tf[31], s3_tf}) - tphc_pkg::TFinePressOfs;
      s4_xh   <= s3_tf - tphc_pkg::TFineHumOfs;
      s4_ap   <= s3_ap;
      s4_ah   <= s3_ah;
    end
  end

  // stage 5: first products
  logic signed [65:0] vv_full;
  logic signed [48:0] v1p5_full, v1p2_full;
  logic signed [47:0] h5x_full;
  logic signed [39:0] xb_full;
  logic signed [40:0] xe_full;
  logic [63:0] s5_vv;
  logic signed [48:0] s5_v1p5, s5_v1p2;
  logic [31:0] s5_h5x, s5_xb, s5_xe, s5_temp;
  logic [19:0] s5_ap;
  logic [15:0] s5_ah;

  assign vv_full   = s4_v1 * s4_v1;
  assign v1p5_full = s4_v1 * p5;
  assign v1p2_full = s4_v1 * p2;
  assign h5x_full  = $signed(s4_xh) * h5;
  assign xb_full   = $signed(s4_xh) * h6;
  assign xe_full   = $signed(s4_xh) * $signed({1'b0, h3});

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vv   <= vv_full[63:0];
      s5_v1p5 <= v1p5_full;
      s5_v1p2 <= v1p2_full;
      s5_h5x  <= h5x_full[31:0];
      s5_xb   <= xb_full[31:0];
      s5_xe   <= xe_full[31:0];
      s5_temp <= s4_temp;
      s5_ap   <= s4_ap;
      s5_ah   <= s4_ah;
    end
  end

  // stage 6
  logic signed [79:0] v2a_full, v13_full;
  logic [31:0] hsum;
  logic [63:0] s6_v2a, s6_v13;
  logic signed [48:0] s6_v1p5, s6_v1p2;
  logic [31:0] s6_ha, s6_hb, s6_he, s6_temp;
  logic [19:0] s6_ap;

  assign v2a_full = $signed(s5_vv) * p6;
  assign v13_full = $signed(s5_vv) * p3;
  assign hsum     = {2'b0, s5_ah, 14'b0} - {h4[11:0], 20'b0} - s5_h5x + tphc_pkg::HumRndA;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_v2a  <= v2a_full[63:0];
      s6_v13  <= v13_full[63:0];
      s6_v1p5 <= s5_v1p5;
      s6_v1p2 <= s5_v1p2;
      s6_ha   <= 32'($signed(hsum) >>> 15);
      s6_hb   <= 32'($signed(s5_xb) >>> 10);
      s6_he   <= 32'($signed(s5_xe) >>> 11) + tphc_pkg::HumOfsE;
      s6_temp <= s5_temp;
      s6_ap   <= s5_ap;
    end
  end

  // stage 7
  logic signed [63:0] v1p5_64, v1p2_64, p4_64;
  logic [63:0] v1b;
  logic signed [63:0] hbe_full;
  logic [63:0] s7_v2, s7_w;
  logic [31:0] s7_hbe, s7_ha, s7_temp;
  logic [19:0] s7_ap;

  assign v1p5_64  = 64'(s6_v1p5);
  assign v1p2_64  = 64'(s6_v1p2);
  assign p4_64    = 64'(p4);
  assign v1b      = 64'($signed(s6_v13) >>> 8) + 64'(v1p2_64 << 12);
  assign hbe_full = $signed(s6_hb) * $signed(s6_he);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_v2   <= s6_v2a + 64'(v1p5_64 << 17) + 64'(p4_64 << 35);
      s7_w    <= v1b + tphc_pkg::PressBias;
      s7_hbe  <= hbe_full[31:0];
      s7_ha   <= s6_ha;
      s7_temp <= s6_temp;
      s7_ap   <= s6_ap;
    end
  end

  // stage 8
  logic signed [80:0] v1c_full;
  logic [20:0] pbase;
  logic [63:0] s8_v1c, s8_num0;
  logic [31:0] s8_hf, s8_ha, s8_temp;

  assign v1c_full = $signed(s7_w) * $signed({1'b0, p1});
  assign pbase    = tphc_pkg::PressFull - {1'b0, s7_ap};

  always_ff @(posedge clk) begin
    if (en) begin
      s8_v1c  <= v1c_full[63:0];
      s8_num0 <= {12'b0, pbase, 31'b0} - s7_v2;
      s8_hf   <= 32'($signed(s7_hbe) >>> 10) + tphc_pkg::HumOfsF;
      s8_ha   <= s7_ha;
      s8_temp <= s7_temp;
    end
  end

  // stage 9
  logic [76:0] num_full;
  logic signed [47:0] hfh_full;
  logic [63:0] s9_num, s9_den;
  logic [31:0] s9_hfh, s9_ha, s9_temp;

  assign num_full = s8_num0 * tphc_pkg::PressScale;
  assign hfh_full = $signed(s8_hf) * h2;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_num  <= num_full[63:0];
      s9_den  <= 64'($signed(s8_v1c) >>> 33);
      s9_hfh  <= hfh_full[31:0];
      s9_ha   <= s8_ha;
      s9_temp <= s8_temp;
    end
  end

  // stage 10: divider operands
  tphc_pkg::div_xact_t opnd [10:14];
  logic [31:0] hfh_r;
  logic [31:0] s10_hff, s10_ha, s10_temp;

  assign hfh_r = s9_hfh + tphc_pkg::HumRndF;

  always_ff @(posedge clk) begin
    if (en) begin
      opnd[10].num  <= s9_num[63] ? (64'd0 - s9_num) : s9_num;
      opnd[10].den  <= s9_den[63] ? (64'd0 - s9_den) : s9_den;
      opnd[10].neg  <= s9_num[63] ^ s9_den[63];
      opnd[10].zero <= (s9_den == 64'd0);
      opnd[10].tag  <= '0;
      s10_hff       <= 32'($signed(hfh_r) >>> 14);
      s10_ha        <= s9_ha;
      s10_temp      <= s9_temp;
      for (int i = 11; i <= 14; i++) begin
        opnd[i] <= opnd[i-1];
      end
    end
  end

  // stage 11
  logic signed [63:0] hx_full;
  logic [31:0] s11_hx, s11_temp;

  assign hx_full = $signed(s10_ha) * $signed(s10_hff);

  always_ff @(posedge clk) begin
    if (en) begin
      s11_hx   <= hx_full[31:0];
      s11_temp <= s10_temp;
    end
  end

  // stage 12
  logic signed [16:0] hs;
  logic signed [33:0] hss_full;
  logic [31:0] s12_hss, s12_hx, s12_temp;

  assign hs       = 17'($signed(s11_hx) >>> 15);
  assign hss_full = hs * hs;

  always_ff @(posedge clk) begin
    if (en) begin
      s12_hss  <= hss_full[31:0];
      s12_hx   <= s11_hx;
      s12_temp <= s11_temp;
    end
  end

  // stage 13
  logic signed [31:0] hss_sh;
  logic signed [40:0] hm_full;
  logic [31:0] s13_hm, s13_hx, s13_temp;

  assign hss_sh  = $signed(s12_hss) >>> 7;
  assign hm_full = hss_sh * $signed({1'b0, h1});

  always_ff @(posedge clk) begin
    if (en) begin
      s13_hm   <= hm_full[31:0];
      s13_hx   <= s12_hx;
      s13_temp <= s12_temp;
    end
  end

  // stage 14: humidity clamp
  logic [31:0] hy, hy_clamp;
  logic [16:0] s14_hum;
  logic [31:0] s14_temp;

  assign hy = s13_hx - 32'($signed(s13_hm) >>> 4);

  always_comb begin
    if (hy[31]) begin
      hy_clamp = '0;
    end else if (hy > tphc_pkg::HumMax) begin
      hy_clamp = tphc_pkg::HumMax;
    end else begin
      hy_clamp = hy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s14_hum  <= hy_clamp[28:12];
      s14_temp <= s13_temp;
    end
  end

  // divider
  tphc_pkg::div_xact_t div_in, div_out;

  always_comb begin
    div_in                   = opnd[14];
    div_in.tag.temp_centideg = $signed(s14_temp);
    div_in.tag.press_q24_8   = '0;
    div_in.tag.hum_q22_10    = s14_hum;
  end

  tphc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pre_v[14]),
    .in_data   (div_in),
    .out_valid (div_out_v),
    .out_data  (div_out)
  );

  // post stage 1: signed quotient
  logic [63:0] q1;
  logic        z1;
  tphc_pkg::result_t g1;

  always_ff @(posedge clk) begin
    if (en) begin
      q1 <= div_out.neg ? (64'd0 - div_out.num) : div_out.num;
      z1 <= div_out.zero;
      g1 <= div_out.tag;
    end
  end

  // post stage 2: split square of q >> 13, and p8 product
  logic signed [63:0] qs;
  logic [63:0] mll_full;
  logic [63:0] mhl_full;
  logic signed [79:0] p8q_full;
  logic [63:0] q2, mll2, p8q2;
  logic [31:0] mhl2;
  logic        z2;
  tphc_pkg::result_t g2;

  assign qs       = $signed(q1) >>> 13;
  assign mll_full = qs[31:0] * qs[31:0];
  assign mhl_full = qs[63:32] * qs[31:0];
  assign p8q_full = $signed(q1) * p8;

  always_ff @(posedge clk) begin
    if (en) begin
      mll2 <= mll_full;
      mhl2 <= mhl_full[31:0];
      p8q2 <= p8q_full[63:0];
      q2   <= q1;
      z2   <= z1;
      g2   <= g1;
    end
  end

  // post stage 3
  logic [63:0] ss3, p8q3, q3;
  logic        z3;
  tphc_pkg::result_t g3;

  always_ff @(posedge clk) begin
    if (en) begin
      ss3  <= mll2 + {mhl2[30:0], 33'b0};
      p8q3 <= p8q2;
      q3   <= q2;
      z3   <= z2;
      g3   <= g2;
    end
  end

  // post stage 4
  logic signed [79:0] v1e_full;
  logic [63:0] v1e4, p8q4, q4;
  logic        z4;
  tphc_pkg::result_t g4;

  assign v1e_full = $signed(ss3) * p9;

  always_ff @(posedge clk) begin
    if (en) begin
      v1e4 <= v1e_full[63:0];
      p8q4 <= p8q3;
      q4   <= q3;
      z4   <= z3;
      g4   <= g3;
    end
  end

  // post stage 5
  logic [63:0] t5s;
  logic        z5;
  tphc_pkg::result_t g5;

  always_ff @(posedge clk) begin
    if (en) begin
      t5s <= q4 + 64'($signed(v1e4) >>> 25) + 64'($signed(p8q4) >>> 19);
      z5  <= z4;
      g5  <= g4;
    end
  end

  // post stage 6: final pressure
  logic signed [63:0] p7_64;
  logic [63:0] pr;

  assign p7_64 = 64'(p7);
  assign pr    = 64'($signed(t5s) >>> 8) + 64'(p7_64 << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      tail_d <= {g5.temp_centideg, (z5 ? 32'd0 : pr[31:0]), g5.hum_q22_10};
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= skid_v || post_v[6];
      skid_v       <= 1'b0;
    end else if (post_v[6] && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_v ? skid_d : tail_d;
    end else if (post_v[6] && !skid_v) begin
      skid_d <= tail_d;
    end
  end

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid holds a transaction while output is empty");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid && result_stall && post_v[6]))
    else $error("skid filled without a stalled output");

  a_hum_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.hum_q22_10 <= 17'd102400)
    else $error("humidity above clamp");

endmodule

// File: test/temp_press_hum_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_press_hum_compensation_test
// Self-checking bench for the compensation pipeline. Random and corner raw
// readings go in under several calibration sets. Each result is compared
// field by field with a behavioral prediction; the sample side gets random
// gaps and the result side random stalls.
// ----------------------------------------------------------------------------
module temp_press_hum_compensation_test;

  class comp_scoreboard;
    logic [63:0]       cal [5];
    tphc_pkg::result_t pending [$];
    int                errors;
    int                checked;

    function new();
      foreach (cal[i]) cal[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_cal(int idx, logic [63:0] val);
      case (idx)
        tphc_pkg::REG_TEMP:  cal[idx] = val & 64'hFFFF_FFFF_FFFF;
        tphc_pkg::REG_P9_H1: cal[idx] = val & 64'hFF_FFFF;
        default:             cal[idx] = val;
      endcase
    endfunction

    function tphc_pkg::result_t compensate(tphc_pkg::sample_t s);
      tphc_pkg::result_t r;
      logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
      logic signed [31:0] at, ah, a, b, d, tf, x, e, f;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, num, den;
      logic [63:0] un, ud, q;
      t1 = {16'd0, cal[0][15:0]};
      t2 = {{16{cal[0][31]}}, cal[0][31:16]};
      t3 = {{16{cal[0][47]}}, cal[0][47:32]};
      p1 = {48'd0, cal[1][15:0]};
      p2 = {{48{cal[1][31]}}, cal[1][31:16]};
      p3 = {{48{cal[1][47]}}, cal[1][47:32]};
      p4 = {{48{cal[1][63]}}, cal[1][63:48]};
      p5 = {{48{cal[2][15]}}, cal[2][15:0]};
      p6 = {{48{cal[2][31]}}, cal[2][31:16]};
      p7 = {{48{cal[2][47]}}, cal[2][47:32]};
      p8 = {{48{cal[2][63]}}, cal[2][63:48]};
      p9 = {{48{cal[3][15]}}, cal[3][15:0]};
      h1 = {24'd0, cal[3][23:16]};
      h2 = {{16{cal[4][15]}}, cal[4][15:0]};
      h3 = {24'd0, cal[4][23:16]};
      h4 = {{16{cal[4][39]}}, cal[4][39:24]};
      h5 = {{16{cal[4][55]}}, cal[4][55:40]};
      h6 = {{24{cal[4][63]}}, cal[4][63:56]};
      at = {12'd0, s.raw_temp};
      ah = {16'd0, s.raw_hum};

      a  = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d  = (at >>> 4) - t1;
      b  = (((d * d) >>> 12) * t3) >>> 14;
      tf = a + b;
      r.temp_centideg = (tf * 5 + 128) >>> 8;

      v1 = 64'(tf) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.press_q24_8 = '0;
      end else begin
        p   = 64'sd1048576 - $signed({44'd0, s.raw_press});
        num = ((p <<< 31) - v2) * 64'sd3125;
        den = v1;
        un  = num[63] ? -num : num;
        ud  = den[63] ? -den : den;
        q   = un / ud;
        p   = (num[63] != den[63]) ? -q : q;
        v1  = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        v2  = (p8 * p) >>> 19;
        p   = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        r.press_q24_8 = p[31:0];
      end

      x = tf - 32'sd76800;
      a = ((ah <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
      b = (x * h6) >>> 10;
      e = ((x * h3) >>> 11) + 32'sd32768;
      f = ((b * e) >>> 10) + 32'sd2097152;
      f = (f * h2 + 32'sd8192) >>> 14;
      x = a * f;
      x = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      else if (x > 32'sd419430400) x = 32'sd419430400;
      r.hum_q22_10 = x[28:12];
      return r;
    endfunction

    function void note_sample(tphc_pkg::sample_t s);
      pending.push_back(compensate(s));
    endfunction

    function void check_result(tphc_pkg::result_t got);
      tphc_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.temp_centideg !== want.temp_centideg) begin
        $display("%0t: temp expected %0d actual %0d", $time,
                 want.temp_centideg, got.temp_centideg);
        errors++;
      end
      if (got.press_q24_8 !== want.press_q24_8) begin
        $display("%0t: press expected %h actual %h", $time,
                 want.press_q24_8, got.press_q24_8);
        errors++;
      end
      if (got.hum_q22_10 !== want.hum_q22_10) begin
        $display("%0t: hum expected %h actual %h", $time,
                 want.hum_q22_10, got.hum_q22_10);
        errors++;
      end
    endfunction
  endclass

  localparam int Latency  = 85;
  localparam int Watchdog = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  tphc_pkg::sample_t sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tphc_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [tphc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tphc_pkg::CfgDataW-1:0] cfg_data = '0;

  comp_scoreboard sb = new();
  int  idle_pct = 28;
  int  idle_cycles = 0;
  int  samples_sent = 0;
  bit  timed_out = 1'b0;

  always #4 clk = ~clk;

  temp_press_hum_compensation i_dut (.*);

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (!rst && (idle_pct > 0) && ($urandom_range(99) < idle_pct))
      result_stall <= 1'b1;
    else
      result_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Watchdog && !timed_out) begin
      timed_out = 1'b1;
      $display("temp_press_hum_compensation_test: FAIL");
      $finish;
    end
  end

  // cfg_valid stays high after a write; the next sample clears it
  task automatic write_cal(tphc_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_cal(idx, val);
  endtask

  task automatic write_bad_index();
    cfg_valid <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data  <= {$urandom, $urandom};
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_sample(tphc_pkg::sample_t s);
    cfg_valid <= 1'b0;
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  // typical datasheet-like calibration
  task automatic load_nominal_cal();
    write_cal(tphc_pkg::REG_TEMP,     {16'hFC18, 16'd26435, 16'd27504});
    write_cal(tphc_pkg::REG_PRESS_LO, {16'd2855, 16'd3024, 16'hD4BD, 16'd36477});
    write_cal(tphc_pkg::REG_PRESS_HI, {16'hC70C, 16'd15500, 16'hFFF9, 16'd140});
    write_cal(tphc_pkg::REG_P9_H1,    {8'd75, 16'd6000});
    write_cal(tphc_pkg::REG_HUM,      {8'd30, 16'd50, 16'd313, 8'd0, 16'd362});
  endtask

  task automatic load_random_cal();
    write_cal(tphc_pkg::REG_TEMP,     {$urandom, $urandom});
    write_cal(tphc_pkg::REG_PRESS_LO, {$urandom, $urandom});
    write_cal(tphc_pkg::REG_PRESS_HI, {$urandom, $urandom});
    write_cal(tphc_pkg::REG_P9_H1,    {$urandom, $urandom});
    write_cal(tphc_pkg::REG_HUM,      {$urandom, $urandom});
  endtask

  function automatic tphc_pkg::sample_t near_nominal();
    tphc_pkg::sample_t s;
    s.raw_temp  = 20'd519888 + 20'($signed($urandom_range(200000)) - 100000);
    s.raw_press = 20'd415148 + 20'($signed($urandom_range(300000)) - 150000);
    s.raw_hum   = 16'($urandom_range(65535));
    return s;
  endfunction

  function automatic tphc_pkg::sample_t any_sample();
    tphc_pkg::sample_t s;
    s.raw_temp  = 20'($urandom);
    s.raw_press = 20'($urandom);
    s.raw_hum   = 16'($urandom);
    return s;
  endfunction

  task automatic random_batch(int n, bit nominal);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) idle_pct = 0;
      if (i == n / 3 + 60) idle_pct = 28;
      send_sample((nominal && $urandom_range(9) != 0) ? near_nominal() : any_sample());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero coefficients: zero divisor path
    send_sample('0);
    send_sample('1);
    drain();

    load_nominal_cal();
    send_sample({20'd519888, 20'd415148, 16'd30000});
    send_sample('0);
    send_sample('1);
    send_sample({20'hFFFFF, 20'd0, 16'hFFFF});
    send_sample({20'd0, 20'hFFFFF, 16'd0});
    send_sample({20'h55555, 20'hAAAAA, 16'h5A5A});
    send_sample({20'hAAAAA, 20'h55555, 16'hA5A5});
    drain();

    // most negative numerator over minus one style extremes and full-scale coeffs
    write_cal(tphc_pkg::REG_TEMP,     64'hFFFF_FFFF_FFFF);
    write_cal(tphc_pkg::REG_PRESS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(tphc_pkg::REG_PRESS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(tphc_pkg::REG_P9_H1,    64'hFF_FFFF);
    write_cal(tphc_pkg::REG_HUM,      64'hFFFF_FFFF_FFFF_FFFF);
    write_bad_index();
    send_sample('0);
    send_sample('1);
    send_sample({20'd1, 20'd1, 16'd1});
    send_sample({20'h80000, 20'h80000, 16'h8000});
    drain();

    write_cal(tphc_pkg::REG_TEMP,     {16'h8000, 16'h8000, 16'h0000});
    write_cal(tphc_pkg::REG_PRESS_LO, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
    write_cal(tphc_pkg::REG_PRESS_HI, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    write_cal(tphc_pkg::REG_P9_H1,    {8'h80, 16'h8000});
    write_cal(tphc_pkg::REG_HUM,      {8'h80, 16'h8000, 16'h7FFF, 8'hFF, 16'h8000});
    send_sample('0);
    send_sample('1);
    send_sample({20'h7FFFF, 20'h7FFFF, 16'h7FFF});
    drain();

    load_nominal_cal();
    random_batch(500, 1'b1);
    drain();

    for (int k = 0; k < 4; k++) begin
      load_random_cal();
      random_batch(100, 1'b0);
      drain();
    end

    $display("Checked %0d results from %0d readings under nominal, extreme and",
             sb.checked, samples_sent);
    $display("random calibration sets, with random gaps and back-pressure.");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("temp_press_hum_compensation_test: PASS");
    else
      $display("temp_press_hum_compensation_test: FAIL");
    $finish;
  end
endmodule
